### src/color_period_average_calibrate_defines.svh
// Assertion macros for the color period averaging block.
// Used by the port checker; no other dependencies.
`ifndef COLOR_PERIOD_AVERAGE_CALIBRATE_DEFINES_SVH
`define COLOR_PERIOD_AVERAGE_CALIBRATE_DEFINES_SVH

// same-cycle implication, reset masked
`define CPAC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cpac assertion failed");

// next-cycle implication, reset masked
`define CPAC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cpac assertion failed");

`endif

### src/cpac_pkg.sv
// Shared widths, register codes, reset values and lane control types.
// No dependencies.
package cpac_pkg;

  localparam int W_WIDTH = 17;
  localparam int W_SUM   = 25;
  localparam int W_CNT   = 8;
  localparam int W_LEVEL = 8;
  localparam int W_IDX   = 3;
  localparam int W_STEP  = 5;

  localparam logic [W_STEP-1:0]  DIV_LAST    = 5'd24;
  localparam logic [W_WIDTH-1:0] WIDTH_LIMIT = 17'd100000;
  localparam logic [W_CNT-1:0]   MAX_SETS    = 8'd255;
  localparam logic [W_LEVEL-1:0] LEVEL_MAX   = 8'd255;

  localparam logic [W_IDX-1:0] CFG_NUM_READINGS = 3'd0;
  localparam logic [W_IDX-1:0] CFG_WHITE_RED    = 3'd1;
  localparam logic [W_IDX-1:0] CFG_WHITE_GREEN  = 3'd2;
  localparam logic [W_IDX-1:0] CFG_WHITE_BLUE   = 3'd3;
  localparam logic [W_IDX-1:0] CFG_BLACK_RED    = 3'd4;
  localparam logic [W_IDX-1:0] CFG_BLACK_GREEN  = 3'd5;
  localparam logic [W_IDX-1:0] CFG_BLACK_BLUE   = 3'd6;

  localparam logic [W_CNT-1:0]   RST_NUM_READINGS = 8'd1;
  localparam logic [W_WIDTH-1:0] RST_WHITE        = 17'd50;
  localparam logic [W_WIDTH-1:0] RST_BLACK        = 17'd1000;

  typedef struct packed {
    logic             acc;
    logic             fin;
    logic             take;
    logic [W_CNT-1:0] count;
  } lane_ctrl_t;

  typedef struct packed {
    logic done;
  } lane_stat_t;

  function automatic logic [W_WIDTH-1:0] clip_width(input logic [W_WIDTH-1:0] w);
    return (w > WIDTH_LIMIT) ? WIDTH_LIMIT : w;
  endfunction

endpackage

### src/cpac_if.sv
// Handshake channels of the block: input word, result word, config write.
// Depends on cpac_pkg.
interface cpac_in_if;
  logic                         valid;
  logic                         ready;
  logic [cpac_pkg::W_WIDTH-1:0] width_red;
  logic [cpac_pkg::W_WIDTH-1:0] width_green;
  logic [cpac_pkg::W_WIDTH-1:0] width_blue;
  modport source (output valid, width_red, width_green, width_blue, input ready);
  modport sink (input valid, width_red, width_green, width_blue, output ready);
endinterface

interface cpac_out_if;
  logic                         valid;
  logic                         ready;
  logic [cpac_pkg::W_WIDTH-1:0] avg_red;
  logic [cpac_pkg::W_WIDTH-1:0] avg_green;
  logic [cpac_pkg::W_WIDTH-1:0] avg_blue;
  logic [cpac_pkg::W_LEVEL-1:0] level_red;
  logic [cpac_pkg::W_LEVEL-1:0] level_green;
  logic [cpac_pkg::W_LEVEL-1:0] level_blue;
  modport source (output valid, avg_red, avg_green, avg_blue,
                  level_red, level_green, level_blue, input ready);
  modport sink (input valid, avg_red, avg_green, avg_blue,
                level_red, level_green, level_blue, output ready);
endinterface

interface cpac_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cpac_pkg::W_IDX-1:0]   index;
  logic [cpac_pkg::W_WIDTH-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/cpac_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, 25 steps.
// Depends on cpac_pkg.
module cpac_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cpac_pkg::W_SUM-1:0] dividend_i,
  input  logic [cpac_pkg::W_WIDTH-1:0] divisor_i,
  output logic                       done_o,
  output logic [cpac_pkg::W_SUM-1:0] quot_o
);

  logic [cpac_pkg::W_SUM-1:0]   quot_q, quot_d;
  logic [cpac_pkg::W_WIDTH-1:0] rem_q, rem_d;
  logic [cpac_pkg::W_WIDTH-1:0] dvs_q, dvs_d;
  logic [cpac_pkg::W_STEP-1:0]  step_q, step_d;
  logic                         run_q, run_d;
  logic                         done_q, done_d;
  logic [cpac_pkg::W_WIDTH:0]   rem_sh;
  logic [cpac_pkg::W_WIDTH:0]   rem_sub;
  logic                         ge;

  always_comb begin
    rem_sh  = {rem_q, quot_q[cpac_pkg::W_SUM-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    step_d  = step_q;
    run_d   = run_q;
    done_d  = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      quot_d = {quot_q[cpac_pkg::W_SUM-2:0], ge};
      rem_d  = ge ? rem_sub[cpac_pkg::W_WIDTH-1:0] : rem_sh[cpac_pkg::W_WIDTH-1:0];
      step_d = step_q + 5'd1;
      if (step_q == cpac_pkg::DIV_LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### src/cpac_lane.sv
// One color lane: running sum, average and calibrated level through cpac_div.
// Depends on cpac_pkg and cpac_div.
module cpac_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cpac_pkg::lane_ctrl_t         ctrl_i,
  input  logic [cpac_pkg::W_WIDTH-1:0] width_i,
  input  logic [cpac_pkg::W_WIDTH-1:0] white_i,
  input  logic [cpac_pkg::W_WIDTH-1:0] black_i,
  output cpac_pkg::lane_stat_t         stat_o,
  output logic [cpac_pkg::W_WIDTH-1:0] avg_o,
  output logic [cpac_pkg::W_LEVEL-1:0] level_o
);

  localparam logic [1:0] LN_IDLE = 2'd0;
  localparam logic [1:0] LN_AVG  = 2'd1;
  localparam logic [1:0] LN_LVL  = 2'd2;
  localparam logic [1:0] LN_DONE = 2'd3;

  logic [1:0]                   lane_q, lane_d;
  logic [cpac_pkg::W_SUM-1:0]   sum_q, sum_d;
  logic [cpac_pkg::W_WIDTH-1:0] avg_q, avg_d;
  logic                         neg_q, neg_d;
  logic                         zspan_q, zspan_d;
  logic [cpac_pkg::W_SUM-1:0]   sum_add;
  logic                         div_start;
  logic [cpac_pkg::W_SUM-1:0]   div_dividend;
  logic [cpac_pkg::W_WIDTH-1:0] div_divisor;
  logic                         div_done;
  logic [cpac_pkg::W_SUM-1:0]   quot;
  logic [cpac_pkg::W_WIDTH:0]   diff;
  logic [cpac_pkg::W_WIDTH:0]   span;
  logic [cpac_pkg::W_WIDTH:0]   diff_abs;
  logic [cpac_pkg::W_WIDTH:0]   span_abs;
  logic [cpac_pkg::W_SUM-1:0]   num_mag;

  always_comb begin
    sum_add  = sum_q + {{(cpac_pkg::W_SUM - cpac_pkg::W_WIDTH){1'b0}},
                        cpac_pkg::clip_width(width_i)};
    diff     = {1'b0, quot[cpac_pkg::W_WIDTH-1:0]} - {1'b0, black_i};
    span     = {1'b0, white_i} - {1'b0, black_i};
    diff_abs = diff[cpac_pkg::W_WIDTH] ? -diff : diff;
    span_abs = span[cpac_pkg::W_WIDTH] ? -span : span;
    num_mag  = {diff_abs[cpac_pkg::W_WIDTH-1:0], 8'd0}
             - {8'd0, diff_abs[cpac_pkg::W_WIDTH-1:0]};

    lane_d       = lane_q;
    sum_d        = sum_q;
    avg_d        = avg_q;
    neg_d        = neg_q;
    zspan_d      = zspan_q;
    div_start    = 1'b0;
    div_dividend = sum_add;
    div_divisor  = {{(cpac_pkg::W_WIDTH - cpac_pkg::W_CNT){1'b0}}, ctrl_i.count};

    case (lane_q)
      LN_IDLE: begin
        if (ctrl_i.acc) begin
          sum_d = sum_add;
          if (ctrl_i.fin) begin
            sum_d     = '0;
            div_start = 1'b1;
            lane_d    = LN_AVG;
          end
        end
      end
      LN_AVG: begin
        if (div_done) begin
          avg_d        = quot[cpac_pkg::W_WIDTH-1:0];
          neg_d        = diff[cpac_pkg::W_WIDTH] ^ span[cpac_pkg::W_WIDTH];
          zspan_d      = (span == '0);
          div_start    = 1'b1;
          div_dividend = num_mag;
          div_divisor  = span_abs[cpac_pkg::W_WIDTH-1:0];
          lane_d       = LN_LVL;
        end
      end
      LN_LVL: begin
        if (div_done) begin
          lane_d = LN_DONE;
        end
      end
      LN_DONE: begin
        if (ctrl_i.take) begin
          lane_d = LN_IDLE;
        end
      end
      default: begin
        lane_d = LN_IDLE;
      end
    endcase
  end

  cpac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= LN_IDLE;
      sum_q  <= '0;
    end else begin
      lane_q <= lane_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q   <= avg_d;
    neg_q   <= neg_d;
    zspan_q <= zspan_d;
  end

  always_comb begin
    if (zspan_q || neg_q) begin
      level_o = '0;
    end else if (|quot[cpac_pkg::W_SUM-1:cpac_pkg::W_LEVEL]) begin
      level_o = cpac_pkg::LEVEL_MAX;
    end else begin
      level_o = quot[cpac_pkg::W_LEVEL-1:0];
    end
  end

  assign avg_o       = avg_q;
  assign stat_o.done = (lane_q == LN_DONE);

endmodule

### src/color_period_average_calibrate.sv
// Top level: configuration registers, set counter, three color lanes, result register.
// Depends on cpac_pkg, cpac_if and cpac_lane.
//
// Usage:
//   in_i carries one word of three pulse widths (red, green, blue). Widths above
//   100000 count as 100000. Each word is added to three running sums.
//   When num_readings words have been taken (0 counts as 1), the block divides
//   the sums by the count, maps each average between its black and white point
//   onto 0..255, and offers one result word on out_o.
//   cfg_i writes register index 0..6 (num_readings, white r/g/b, black r/g/b);
//   it is always ready and is meant to be written while the block is idle.
// Flow:
//   Words that do not close a set are taken one per cycle. The word that closes
//   a set drops in_i.ready until its result is loaded: each lane runs two passes
//   of a 25-step bit-serial divider (average, then level), and the result appears
//   on out_o once the second pass has ended in all lanes and the result register
//   is free. With a set size of 1, a new word is taken only after the last result is loaded.
// Reset and stall:
//   Reset clears the sums, the count and out_o.valid and loads the default
//   calibration. A stalled receiver keeps the result word steady; the block
//   keeps taking words for the next set, takes the closing word and then holds
//   in_i off until the result register is free.
module color_period_average_calibrate (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpac_in_if.sink   in_i,
  cpac_out_if.source out_o,
  cpac_cfg_if.sink  cfg_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                         state_q, state_d;
  logic [cpac_pkg::W_CNT-1:0]   sets_q, sets_d;
  logic [cpac_pkg::W_CNT-1:0]   num_q, num_d;
  logic [cpac_pkg::W_WIDTH-1:0] white_r_q, white_r_d;
  logic [cpac_pkg::W_WIDTH-1:0] white_g_q, white_g_d;
  logic [cpac_pkg::W_WIDTH-1:0] white_b_q, white_b_d;
  logic [cpac_pkg::W_WIDTH-1:0] black_r_q, black_r_d;
  logic [cpac_pkg::W_WIDTH-1:0] black_g_q, black_g_d;
  logic [cpac_pkg::W_WIDTH-1:0] black_b_q, black_b_d;
  logic                         ovld_q, ovld_d;
  logic [cpac_pkg::W_WIDTH-1:0] avg_r_q, avg_g_q, avg_b_q;
  logic [cpac_pkg::W_LEVEL-1:0] lvl_r_q, lvl_g_q, lvl_b_q;

  logic [cpac_pkg::W_CNT-1:0]   target;
  logic [cpac_pkg::W_CNT:0]     count;
  logic                         accept;
  logic                         fin;
  logic                         all_done;
  logic                         load;
  cpac_pkg::lane_ctrl_t         ctrl;
  cpac_pkg::lane_stat_t         st_r, st_g, st_b;
  logic [cpac_pkg::W_WIDTH-1:0] avg_r, avg_g, avg_b;
  logic [cpac_pkg::W_LEVEL-1:0] lvl_r, lvl_g, lvl_b;

  always_comb begin
    if (num_q == '0) begin
      target = 8'd1;
    end else if (num_q > cpac_pkg::MAX_SETS) begin
      target = cpac_pkg::MAX_SETS;
    end else begin
      target = num_q;
    end
    count    = {1'b0, sets_q} + 9'd1;
    fin      = count >= {1'b0, target};
    accept   = in_i.valid && (state_q == ST_IDLE);
    all_done = st_r.done && st_g.done && st_b.done;
    load     = (state_q == ST_BUSY) && all_done && (!ovld_q || out_o.ready);

    ctrl.acc   = accept;
    ctrl.fin   = fin;
    ctrl.take  = load;
    ctrl.count = count[cpac_pkg::W_CNT-1:0];

    state_d = state_q;
    sets_d  = sets_q;
    if (accept) begin
      sets_d = fin ? '0 : count[cpac_pkg::W_CNT-1:0];
      if (fin) begin
        state_d = ST_BUSY;
      end
    end
    if (load) begin
      state_d = ST_IDLE;
    end

    ovld_d = ovld_q;
    if (load) begin
      ovld_d = 1'b1;
    end else if (out_o.ready) begin
      ovld_d = 1'b0;
    end

    num_d     = num_q;
    white_r_d = white_r_q;
    white_g_d = white_g_q;
    white_b_d = white_b_q;
    black_r_d = black_r_q;
    black_g_d = black_g_q;
    black_b_d = black_b_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        cpac_pkg::CFG_NUM_READINGS: num_d     = cfg_i.data[cpac_pkg::W_CNT-1:0];
        cpac_pkg::CFG_WHITE_RED:    white_r_d = cfg_i.data;
        cpac_pkg::CFG_WHITE_GREEN:  white_g_d = cfg_i.data;
        cpac_pkg::CFG_WHITE_BLUE:   white_b_d = cfg_i.data;
        cpac_pkg::CFG_BLACK_RED:    black_r_d = cfg_i.data;
        cpac_pkg::CFG_BLACK_GREEN:  black_g_d = cfg_i.data;
        cpac_pkg::CFG_BLACK_BLUE:   black_b_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  cpac_lane u_lane_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .width_i (in_i.width_red),
    .white_i (white_r_q),
    .black_i (black_r_q),
    .stat_o  (st_r),
    .avg_o   (avg_r),
    .level_o (lvl_r)
  );

  cpac_lane u_lane_g (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .width_i (in_i.width_green),
    .white_i (white_g_q),
    .black_i (black_g_q),
    .stat_o  (st_g),
    .avg_o   (avg_g),
    .level_o (lvl_g)
  );

  cpac_lane u_lane_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .width_i (in_i.width_blue),
    .white_i (white_b_q),
    .black_i (black_b_q),
    .stat_o  (st_b),
    .avg_o   (avg_b),
    .level_o (lvl_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sets_q    <= '0;
      ovld_q    <= 1'b0;
      num_q     <= cpac_pkg::RST_NUM_READINGS;
      white_r_q <= cpac_pkg::RST_WHITE;
      white_g_q <= cpac_pkg::RST_WHITE;
      white_b_q <= cpac_pkg::RST_WHITE;
      black_r_q <= cpac_pkg::RST_BLACK;
      black_g_q <= cpac_pkg::RST_BLACK;
      black_b_q <= cpac_pkg::RST_BLACK;
    end else begin
      state_q   <= state_d;
      sets_q    <= sets_d;
      ovld_q    <= ovld_d;
      num_q     <= num_d;
      white_r_q <= white_r_d;
      white_g_q <= white_g_d;
      white_b_q <= white_b_d;
      black_r_q <= black_r_d;
      black_g_q <= black_g_d;
      black_b_q <= black_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      avg_r_q <= avg_r;
      avg_g_q <= avg_g;
      avg_b_q <= avg_b;
      lvl_r_q <= lvl_r;
      lvl_g_q <= lvl_g;
      lvl_b_q <= lvl_b;
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = ovld_q;
  assign out_o.avg_red     = avg_r_q;
  assign out_o.avg_green   = avg_g_q;
  assign out_o.avg_blue    = avg_b_q;
  assign out_o.level_red   = lvl_r_q;
  assign out_o.level_green = lvl_g_q;
  assign out_o.level_blue  = lvl_b_q;

endmodule

### src/cpac_checker.sv
// Port checker for the color period averaging block, bound to the top level.
// Depends on cpac_pkg and color_period_average_calibrate_defines.svh.
`include "color_period_average_calibrate_defines.svh"

module cpac_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [cpac_pkg::W_WIDTH-1:0] avg_red,
  input logic [cpac_pkg::W_WIDTH-1:0] avg_green,
  input logic [cpac_pkg::W_WIDTH-1:0] avg_blue,
  input logic [cpac_pkg::W_LEVEL-1:0] level_red,
  input logic [cpac_pkg::W_LEVEL-1:0] level_green,
  input logic [cpac_pkg::W_LEVEL-1:0] level_blue
);

  logic                                                   stalled;
  logic [3*cpac_pkg::W_WIDTH+3*cpac_pkg::W_LEVEL-1:0]     out_word;

  assign stalled  = out_valid && !out_ready;
  assign out_word = {avg_red, avg_green, avg_blue, level_red, level_green, level_blue};

  `CPAC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, stalled, out_valid)
  `CPAC_ASSERT_NXT(a_word_hold, clk_i, rst_ni, stalled, $stable(out_word))
  `CPAC_ASSERT_IMP(a_result_after_busy, clk_i, rst_ni, $rose(out_valid), $past(!in_ready))
  `CPAC_ASSERT_IMP(a_cfg_open, clk_i, rst_ni, cfg_valid, cfg_ready)

endmodule

bind color_period_average_calibrate cpac_checker u_cpac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .cfg_valid   (cfg_i.valid),
  .cfg_ready   (cfg_i.ready),
  .avg_red     (out_o.avg_red),
  .avg_green   (out_o.avg_green),
  .avg_blue    (out_o.avg_blue),
  .level_red   (out_o.level_red),
  .level_green (out_o.level_green),
  .level_blue  (out_o.level_blue)
);

### bench/color_result_check.sv
`timescale 1ns / 1ps
// Result checker for the color averaging block: watches the input, result and
// register-write channels, predicts each averaged and calibrated result word
// and compares it field by field. Depends on cpac_pkg and cpac_if.
module color_result_check
  import cpac_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cpac_in_if   in_mon,
  cpac_out_if  out_mon,
  cpac_cfg_if  cfg_mon,
  output int   mismatch_count_o,
  output int   results_checked_o,
  output int   results_waiting_o
);

  typedef struct packed {
    logic [2:0][W_WIDTH-1:0] avg;
    logic [2:0][W_LEVEL-1:0] level;
  } color_word_t;

  string hue_name [3] = '{"red", "green", "blue"};

  logic [W_CNT-1:0]        set_size = RST_NUM_READINGS;
  logic [W_WIDTH-1:0]      white_pt [3];
  logic [W_WIDTH-1:0]      black_pt [3];
  logic [W_SUM-1:0]        running_sum [3];
  logic [W_CNT-1:0]        words_taken = '0;
  logic [W_CNT:0]          taken_next;
  logic [W_CNT-1:0]        set_target;
  logic [2:0][W_WIDTH-1:0] hue_width;
  color_word_t             expected_colors [$];
  color_word_t             seen, wanted;

  initial begin
    mismatch_count_o = 0;
    results_checked_o = 0;
    results_waiting_o = 0;
  end

  function automatic logic [W_LEVEL-1:0] calibrated_level(input logic [W_WIDTH-1:0] avg,
                                                          input logic [W_WIDTH-1:0] white,
                                                          input logic [W_WIDTH-1:0] black);
    longint span;
    longint level;
    span = longint'(white) - longint'(black);
    if (span == 0) return '0;
    level = (longint'(avg) - longint'(black)) * longint'(LEVEL_MAX) / span;
    if (level < 0) return '0;
    if (level > longint'(LEVEL_MAX)) return LEVEL_MAX;
    return level[W_LEVEL-1:0];
  endfunction

  task automatic report(input string what);
    $display("MISMATCH %s", what);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size = RST_NUM_READINGS;
      for (int c = 0; c < 3; c++) begin
        white_pt[c] = RST_WHITE;
        black_pt[c] = RST_BLACK;
        running_sum[c] = '0;
      end
      words_taken = '0;
      expected_colors.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen.avg = {out_mon.avg_blue, out_mon.avg_green, out_mon.avg_red};
        seen.level = {out_mon.level_blue, out_mon.level_green, out_mon.level_red};
        if (expected_colors.size() == 0) begin
          report($sformatf("result word %0d arrived with nothing expected",
                           results_checked_o));
        end else begin
          wanted = expected_colors.pop_front();
          for (int c = 0; c < 3; c++) begin
            if (seen.avg[c] !== wanted.avg[c])
              report($sformatf("word %0d avg_%s: got %0d, want %0d", results_checked_o,
                               hue_name[c], seen.avg[c], wanted.avg[c]));
            if (seen.level[c] !== wanted.level[c])
              report($sformatf("word %0d level_%s: got %0d, want %0d", results_checked_o,
                               hue_name[c], seen.level[c], wanted.level[c]));
          end
        end
        results_checked_o++;
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_NUM_READINGS: set_size = cfg_mon.data[W_CNT-1:0];
          CFG_WHITE_RED:    white_pt[0] = cfg_mon.data;
          CFG_WHITE_GREEN:  white_pt[1] = cfg_mon.data;
          CFG_WHITE_BLUE:   white_pt[2] = cfg_mon.data;
          CFG_BLACK_RED:    black_pt[0] = cfg_mon.data;
          CFG_BLACK_GREEN:  black_pt[1] = cfg_mon.data;
          CFG_BLACK_BLUE:   black_pt[2] = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        hue_width = {in_mon.width_blue, in_mon.width_green, in_mon.width_red};
        set_target = (set_size == '0) ? W_CNT'(1) : set_size;
        for (int c = 0; c < 3; c++)
          running_sum[c] = running_sum[c] +
                           W_SUM'((hue_width[c] > WIDTH_LIMIT) ? WIDTH_LIMIT : hue_width[c]);
        taken_next = {1'b0, words_taken} + 1'b1;
        if (taken_next < {1'b0, set_target}) begin
          words_taken = taken_next[W_CNT-1:0];
        end else begin
          for (int c = 0; c < 3; c++) begin
            wanted.avg[c] = W_WIDTH'(running_sum[c] / W_SUM'(taken_next));
            wanted.level[c] = calibrated_level(wanted.avg[c], white_pt[c], black_pt[c]);
            running_sum[c] = '0;
          end
          expected_colors.push_back(wanted);
          words_taken = '0;
        end
      end
    end
    results_waiting_o <= expected_colors.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Bench top for color_period_average_calibrate: clock, reset, register writes,
// pulse-width stimulus and receiver stalls. Depends on cpac_pkg, cpac_if, the
// block and color_result_check.
module testbench;
  import cpac_pkg::*;

  localparam logic [W_IDX-1:0] CFG_UNUSED = 3'd7;
  localparam int unsigned PHASES          = 22;
  localparam int unsigned WORDS_PER_PHASE = 43;
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned CYCLE_LIMIT     = 3_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned words_sent     = 0;
  int unsigned reg_writes     = 0;
  int          mismatches;
  int          results_checked;
  int          results_waiting;

  cpac_in_if  in_ch ();
  cpac_out_if out_ch ();
  cpac_cfg_if cfg_ch ();

  color_period_average_calibrate u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  color_result_check u_color_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_mon            (in_ch),
    .out_mon           (out_ch),
    .cfg_mon           (cfg_ch),
    .mismatch_count_o  (mismatches),
    .results_checked_o (results_checked),
    .results_waiting_o (results_waiting)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(input logic [W_WIDTH-1:0] red, input logic [W_WIDTH-1:0] green,
                           input logic [W_WIDTH-1:0] blue);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.width_red   <= red;
    in_ch.width_green <= green;
    in_ch.width_blue  <= blue;
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic write_reg(input logic [W_IDX-1:0] index, input logic [W_WIDTH-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    reg_writes++;
  endtask

  task automatic end_writes();
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop valid, drain expected words, then let any partial set work finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned             set_size;
    int unsigned             burst;
    logic [W_WIDTH-1:0]      size_data;
    logic [W_WIDTH-1:0]      lo, hi;
    logic [2:0][W_WIDTH-1:0] white, black, width;

    in_ch.valid       <= 1'b0;
    in_ch.width_red   <= '0;
    in_ch.width_green <= '0;
    in_ch.width_blue  <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_NUM_READINGS;
    cfg_ch.data       <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word('0, '0, '0);
    send_word(WIDTH_LIMIT, WIDTH_LIMIT, WIDTH_LIMIT);
    send_word('1, WIDTH_LIMIT + 1'b1, 17'd1000);
    send_word(17'd50, 17'd525, 17'd999);
    settle();

    write_reg(CFG_NUM_READINGS, '0);
    write_reg(CFG_WHITE_RED, WIDTH_LIMIT);
    write_reg(CFG_BLACK_RED, '0);
    write_reg(CFG_WHITE_GREEN, 17'd777);
    write_reg(CFG_BLACK_GREEN, 17'd777);
    write_reg(CFG_WHITE_BLUE, '0);
    write_reg(CFG_BLACK_BLUE, WIDTH_LIMIT);
    write_reg(CFG_UNUSED, '1);
    end_writes();
    send_word(WIDTH_LIMIT, 17'd777, '0);
    send_word(17'd54321, 17'd12345, 17'd65432);
    settle();

    write_reg(CFG_NUM_READINGS, 17'd3);
    end_writes();
    send_word(17'd1000, 17'd2000, 17'd3000);
    send_word(WIDTH_LIMIT, '0, '1);
    settle();
    // shrink the set below the words already taken
    write_reg(CFG_NUM_READINGS, 17'd1);
    end_writes();
    send_word(17'd4, 17'd5, 17'd6);
    settle();

    write_reg(CFG_NUM_READINGS, {9'h1FF, 8'd2});
    end_writes();
    send_word(17'd99999, 17'd1, 17'd65536);
    send_word(17'd1, 17'd99999, 17'd65535);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (phase == 0) set_size = 1;
      else if (phase == 1) set_size = 255;
      else if (phase == 2) set_size = 0;
      else if ($urandom_range(5) == 0) set_size = $urandom_range(254, 13);
      else set_size = $urandom_range(12, 1);
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(7))
          0: begin white[c] = W_WIDTH'($urandom_range(100000)); black[c] = white[c]; end
          1: begin white[c] = '0; black[c] = WIDTH_LIMIT; end
          2: begin white[c] = WIDTH_LIMIT; black[c] = '0; end
          3: begin white[c] = W_WIDTH'($urandom); black[c] = W_WIDTH'($urandom); end
          4: begin
            white[c] = W_WIDTH'($urandom_range(100000));
            black[c] = W_WIDTH'($urandom_range(100000));
          end
          default: begin
            white[c] = W_WIDTH'($urandom_range(2000, 20));
            black[c] = white[c] + W_WIDTH'($urandom_range(20000, 1));
          end
        endcase
      end
      size_data = (phase % 2 == 1) ? W_WIDTH'($urandom) : '0;
      size_data[W_CNT-1:0] = set_size[W_CNT-1:0];
      write_reg(CFG_NUM_READINGS, size_data);
      write_reg(CFG_WHITE_RED, white[0]);
      write_reg(CFG_WHITE_GREEN, white[1]);
      write_reg(CFG_WHITE_BLUE, white[2]);
      write_reg(CFG_BLACK_RED, black[0]);
      write_reg(CFG_BLACK_GREEN, black[1]);
      write_reg(CFG_BLACK_BLUE, black[2]);
      end_writes();

      burst = (set_size > 40) ? set_size + $urandom_range(10) : WORDS_PER_PHASE;
      repeat (burst) begin
        for (int c = 0; c < 3; c++) begin
          lo = (white[c] < black[c]) ? white[c] : black[c];
          hi = (white[c] < black[c]) ? black[c] : white[c];
          case ($urandom_range(9))
            0: width[c] = '0;
            1: width[c] = WIDTH_LIMIT + 1'b1 + W_WIDTH'($urandom_range(31070));
            2: width[c] = W_WIDTH'($urandom);
            default: width[c] = W_WIDTH'($urandom_range(hi, lo));
          endcase
        end
        send_word(width[0], width[1], width[2]);
      end
      settle();
    end

    $display("Sent %0d pulse-width words and %0d register writes over %0d phases;",
             words_sent, reg_writes, PHASES);
    $display("checked %0d averaged result words, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && results_waiting == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
